[rtl/crp_pkg.sv]
// shared types, mode codes and character constants for the comment stripper
package crp_pkg;

    localparam int FIFO_DEPTH = 4;

    localparam logic [3:0] M_CODE       = 4'd0;
    localparam logic [3:0] M_HELD_PAREN = 4'd1;
    localparam logic [3:0] M_HELD_SLASH = 4'd2;
    localparam logic [3:0] M_LINE       = 4'd3;
    localparam logic [3:0] M_BRACE      = 4'd4;
    localparam logic [3:0] M_PAREN      = 4'd5;
    localparam logic [3:0] M_PAREN_STAR = 4'd6;
    localparam logic [3:0] M_STRING     = 4'd7;
    localparam logic [3:0] M_STR_QUOTE  = 4'd8;

    localparam logic [7:0] CH_LBRACE  = 8'h7B;
    localparam logic [7:0] CH_RBRACE  = 8'h7D;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_QUOTE   = 8'h27;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;

    // up to two bytes produced by one input word, plus its end flag
    typedef struct packed {
        logic [7:0] b0;
        logic [7:0] b1;
        logic [1:0] cnt;
        logic       last;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_stat;

endpackage

[rtl/crp_front.sv]
// scanner: classifies each input byte and queues the bytes it passes through
module crp_front import crp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  logic       i_full,
    input  logic [7:0] i_char,
    input  logic       i_last,
    output logic       o_cmd_push,
    output t_cmd       o_cmd
);

    logic [3:0] r_mode;
    logic [3:0] n_mode;
    t_cmd       cmd;
    logic       do_code;
    logic       accept;

    function automatic t_cmd put(input t_cmd c, input logic [7:0] ch);
        t_cmd r;
        r = c;
        if (c.cnt == 2'd0) begin
            r.b0 = ch;
        end else begin
            r.b1 = ch;
        end
        if (c.cnt != 2'd2) begin
            r.cnt = c.cnt + 2'd1;
        end
        return r;
    endfunction

    assign accept = i_push && !i_full;

    always_comb begin
        cmd     = '0;
        n_mode  = r_mode;
        do_code = 1'b0;
        case (r_mode)
            M_HELD_PAREN: begin
                if (i_char == CH_STAR) begin
                    n_mode = M_PAREN;
                end else begin
                    cmd     = put(cmd, CH_LPAREN);
                    do_code = 1'b1;
                end
            end
            M_HELD_SLASH: begin
                if (i_char == CH_SLASH) begin
                    n_mode = M_LINE;
                end else begin
                    cmd     = put(cmd, CH_SLASH);
                    do_code = 1'b1;
                end
            end
            M_LINE: begin
                if (i_char == CH_NEWLINE) begin
                    cmd    = put(cmd, CH_NEWLINE);
                    n_mode = M_CODE;
                end
            end
            M_BRACE: begin
                if (i_char == CH_RBRACE) begin
                    n_mode = M_CODE;
                end
            end
            M_PAREN: begin
                if (i_char == CH_STAR) begin
                    n_mode = M_PAREN_STAR;
                end
            end
            M_PAREN_STAR: begin
                if (i_char == CH_RPAREN) begin
                    n_mode = M_CODE;
                end else if (i_char != CH_STAR) begin
                    n_mode = M_PAREN;
                end
            end
            M_STRING: begin
                cmd = put(cmd, i_char);
                if (i_char == CH_QUOTE) begin
                    n_mode = M_STR_QUOTE;
                end
            end
            M_STR_QUOTE: begin
                if (i_char == CH_QUOTE) begin
                    cmd    = put(cmd, i_char);
                    n_mode = M_STRING;
                end else begin
                    do_code = 1'b1;
                end
            end
            default: begin
                do_code = 1'b1;
            end
        endcase

        // byte seen in plain code
        if (do_code) begin
            if (i_char == CH_LBRACE) begin
                n_mode = M_BRACE;
            end else if (i_char == CH_LPAREN) begin
                n_mode = M_HELD_PAREN;
            end else if (i_char == CH_SLASH) begin
                n_mode = M_HELD_SLASH;
            end else begin
                cmd    = put(cmd, i_char);
                n_mode = (i_char == CH_QUOTE) ? M_STRING : M_CODE;
            end
        end

        // end of text: flush a held char, back to code
        if (i_last) begin
            if (n_mode == M_HELD_PAREN) begin
                cmd = put(cmd, CH_LPAREN);
            end else if (n_mode == M_HELD_SLASH) begin
                cmd = put(cmd, CH_SLASH);
            end
            n_mode = M_CODE;
        end
        cmd.last = i_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_CODE;
        end else if (accept) begin
            r_mode <= n_mode;
        end
    end

    assign o_cmd_push = accept && ((cmd.cnt != 2'd0) || i_last);
    assign o_cmd      = cmd;

endmodule

[rtl/crp_fifo.sv]
// short command queue between scanner and output stage
module crp_fifo import crp_pkg::*; #(
    parameter int DEPTH = FIFO_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_wr,
    input  t_cmd       i_data,
    input  logic       i_rd,
    output t_cmd       o_data,
    output t_fifo_stat o_stat
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_cmd          r_mem [DEPTH];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [CW-1:0] r_cnt;
    logic          wr_en;
    logic          rd_en;

    assign o_stat.full  = (r_cnt == FULL_CNT);
    assign o_stat.empty = (r_cnt == '0);
    assign wr_en = i_wr && !o_stat.full;
    assign rd_en = i_rd && !o_stat.empty;
    assign o_data = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr_en) begin
                r_wr <= (r_wr == LAST_IDX) ? '0 : r_wr + AW'(1);
            end
            if (rd_en) begin
                r_rd <= (r_rd == LAST_IDX) ? '0 : r_rd + AW'(1);
            end
            if (wr_en && !rd_en) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (rd_en && !wr_en) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule

[rtl/crp_back.sv]
// output stage: expands queued commands into result words one per cycle while the reader pops
module crp_back import crp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd       i_cmd,
    input  logic       i_cmd_empty,
    output logic       o_cmd_pop,
    input  logic       i_pop,
    output logic       o_empty,
    output logic [7:0] o_out_char,
    output logic       o_out_valid,
    output logic       o_run_last,
    output logic       o_stream_end
);

    logic       r_full;
    logic       r_second;
    logic [7:0] r_char;
    logic       r_valid;
    logic       r_run_last;
    logic       r_stream_end;
    logic       load;
    logic       two;
    logic       fin;

    assign load = !i_cmd_empty && (!r_full || i_pop);
    assign two  = (i_cmd.cnt == 2'd2);
    // a two-byte command stays at the queue head for its first byte
    assign fin  = !two || r_second;
    assign o_cmd_pop = load && fin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full   <= 1'b0;
            r_second <= 1'b0;
        end else begin
            if (load) begin
                r_full   <= 1'b1;
                r_second <= !fin;
            end else if (i_pop) begin
                r_full <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_char       <= r_second ? i_cmd.b1 : ((i_cmd.cnt == 2'd0) ? 8'd0 : i_cmd.b0);
            r_valid      <= (i_cmd.cnt != 2'd0);
            r_run_last   <= fin;
            r_stream_end <= fin && i_cmd.last;
        end
    end

    assign o_empty      = !r_full;
    assign o_out_char   = r_char;
    assign o_out_valid  = r_valid;
    assign o_run_last   = r_run_last;
    assign o_stream_end = r_stream_end;

endmodule

[rtl/pascal_comment_stripper.sv]
// top level: drops brace, paren-star and line comments from a byte stream
// each byte's result words pass through the command queue and then the output register
// throughput: one input byte per cycle while bytes give at most one word each and the reader pops;
//   the single output register moves one word a cycle, so a byte giving two words slows the flow
// a command queue, four entries by default, lets the scanner run ahead of a stalled output
// reset: synchronous active-low i_rst_n empties the queue and returns the scanner to code mode
module pascal_comment_stripper import crp_pkg::*; #(
    parameter int DEPTH = FIFO_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_in_char,
    input  logic       i_in_last,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] o_out_char,
    output logic       o_out_valid,
    output logic       o_run_last,
    output logic       o_stream_end
);

    t_cmd       wr_cmd;
    t_cmd       rd_cmd;
    logic       cmd_push;
    logic       cmd_pop;
    t_fifo_stat q_stat;

    crp_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_full     (q_stat.full),
        .i_char     (i_in_char),
        .i_last     (i_in_last),
        .o_cmd_push (cmd_push),
        .o_cmd      (wr_cmd)
    );

    crp_fifo #(
        .DEPTH (DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (cmd_push),
        .i_data  (wr_cmd),
        .i_rd    (cmd_pop),
        .o_data  (rd_cmd),
        .o_stat  (q_stat)
    );

    crp_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (rd_cmd),
        .i_cmd_empty  (q_stat.empty),
        .o_cmd_pop    (cmd_pop),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_out_char   (o_out_char),
        .o_out_valid  (o_out_valid),
        .o_run_last   (o_run_last),
        .o_stream_end (o_stream_end)
    );

    assign full = q_stat.full;

    a_end_is_run_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_stream_end) |-> o_run_last)
        else $error("stream end word is not the last word of its byte");

    a_marker_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_out_valid) |-> (o_stream_end && (o_out_char == 8'd0)))
        else $error("empty end marker malformed");

    a_queue_stat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_stat.full && q_stat.empty))
        else $error("command queue both full and empty");

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_stat.full |-> !cmd_push)
        else $error("scanner wrote into a full queue");

endmodule

[dv/pascal_comment_stripper_tb.sv]
// self-checking testbench for the pascal comment stripper: directed table, then random text
module pascal_comment_stripper_tb;
    import crp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_GOAL  = 340;
    localparam int MAX_PRINTS  = 100;

    typedef struct packed {
        logic [7:0] ch;
        logic       valid;
        logic       run_last;
        logic       stream_end;
    } t_strip_word;

    typedef struct packed {
        logic [7:0]  c;
        logic        last;
        logic        typed;
        logic [1:0]  n;
        t_strip_word w0;
        t_strip_word w1;
    } t_dir_row;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       push = 1'b0;
    logic       pop = 1'b0;
    logic [7:0] i_in_char = 8'h00;
    logic       i_in_last = 1'b0;
    logic       full;
    logic       empty;
    logic [7:0] o_out_char;
    logic       o_out_valid;
    logic       o_run_last;
    logic       o_stream_end;

    int unsigned send_idle = 0;
    int unsigned recv_idle = 0;
    int unsigned mismatches = 0;
    int unsigned cycles = 0;
    int unsigned sent_items = 0;

    // predictor state and the words still owed by the block
    logic [3:0]  scan_state = M_CODE;
    logic [7:0]  emit_buf [2];
    int          emit_n;
    t_strip_word step_words [$];
    t_strip_word pending_words [$];
    t_dir_row    dir_rows [$];

    pascal_comment_stripper u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_in_char    (i_in_char),
        .i_in_last    (i_in_last),
        .empty        (empty),
        .pop          (pop),
        .o_out_char   (o_out_char),
        .o_out_valid  (o_out_valid),
        .o_run_last   (o_run_last),
        .o_stream_end (o_stream_end)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic t_strip_word mk_word(input logic [7:0] ch, input logic v,
                                            input logic rl, input logic se);
        t_strip_word w;
        w.ch = ch;
        w.valid = v;
        w.run_last = rl;
        w.stream_end = se;
        return w;
    endfunction

    function automatic t_dir_row plain_row(input logic [7:0] c, input logic last);
        t_dir_row r;
        r = '0;
        r.c = c;
        r.last = last;
        return r;
    endfunction

    function automatic t_dir_row typed_row(input logic [7:0] c, input logic last,
                                           input logic [1:0] n, input t_strip_word w0,
                                           input t_strip_word w1);
        t_dir_row r;
        r = plain_row(c, last);
        r.typed = 1'b1;
        r.n = n;
        r.w0 = w0;
        r.w1 = w1;
        return r;
    endfunction

    function automatic void add_row(input t_dir_row r);
        dir_rows.insert(dir_rows.size(), r);
    endfunction

    function automatic void owe_word(input t_strip_word w);
        pending_words.insert(pending_words.size(), w);
    endfunction

    function automatic void put_out(input logic [7:0] c);
        if (emit_n < 2) begin
            emit_buf[emit_n] = c;
            emit_n++;
        end
    endfunction

    function automatic void code_char_in(input logic [7:0] c);
        case (c)
            CH_LBRACE: scan_state = M_BRACE;
            CH_LPAREN: scan_state = M_HELD_PAREN;
            CH_SLASH:  scan_state = M_HELD_SLASH;
            CH_QUOTE: begin
                put_out(c);
                scan_state = M_STRING;
            end
            default: begin
                put_out(c);
                scan_state = M_CODE;
            end
        endcase
    endfunction

    // words that one accepted byte should produce, left in step_words
    function automatic void strip_step(input logic [7:0] c, input logic last);
        emit_n = 0;
        step_words.delete();
        case (scan_state)
            M_HELD_PAREN: begin
                if (c == CH_STAR) begin
                    scan_state = M_PAREN;
                end else begin
                    put_out(CH_LPAREN);
                    code_char_in(c);
                end
            end
            M_HELD_SLASH: begin
                if (c == CH_SLASH) begin
                    scan_state = M_LINE;
                end else begin
                    put_out(CH_SLASH);
                    code_char_in(c);
                end
            end
            M_LINE: begin
                if (c == CH_NEWLINE) begin
                    put_out(CH_NEWLINE);
                    scan_state = M_CODE;
                end
            end
            M_BRACE: begin
                if (c == CH_RBRACE) scan_state = M_CODE;
            end
            M_PAREN: begin
                if (c == CH_STAR) scan_state = M_PAREN_STAR;
            end
            M_PAREN_STAR: begin
                if (c == CH_RPAREN) scan_state = M_CODE;
                else if (c != CH_STAR) scan_state = M_PAREN;
            end
            M_STRING: begin
                put_out(c);
                if (c == CH_QUOTE) scan_state = M_STR_QUOTE;
            end
            M_STR_QUOTE: begin
                if (c == CH_QUOTE) begin
                    put_out(c);
                    scan_state = M_STRING;
                end else begin
                    code_char_in(c);
                end
            end
            default: code_char_in(c);
        endcase

        if (last) begin
            if (scan_state == M_HELD_PAREN) put_out(CH_LPAREN);
            else if (scan_state == M_HELD_SLASH) put_out(CH_SLASH);
            scan_state = M_CODE;
        end

        if (last && emit_n == 0) begin
            // nothing came out of the final byte: empty end marker
            step_words.insert(step_words.size(), mk_word(8'h00, 1'b0, 1'b1, 1'b1));
        end else begin
            for (int k = 0; k < emit_n; k++) begin
                step_words.insert(step_words.size(),
                                  mk_word(emit_buf[k], 1'b1, k == emit_n - 1,
                                          (k == emit_n - 1) && last));
            end
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        if (mismatches < MAX_PRINTS)
            $display("mismatch %s: got %02h want %02h at cycle %0d", what, got, want, cycles);
        mismatches++;
    endtask

    // one byte over the push/full handshake, with random gaps before it
    task automatic push_byte(input logic [7:0] c, input logic last);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push <= 1'b1;
        i_in_char <= c;
        i_in_last <= last;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
    endtask

    task automatic send(input logic [7:0] c, input logic last);
        push_byte(c, last);
        strip_step(c, last);
        sent_items++;
        foreach (step_words[k]) owe_word(step_words[k]);
    endtask

    task automatic drain();
        @(negedge i_clk);
        push <= 1'b0;
        while (pending_words.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [7:0] special_char();
        case ($urandom_range(7))
            0: return CH_LBRACE;
            1: return CH_RBRACE;
            2: return CH_LPAREN;
            3: return CH_STAR;
            4: return CH_RPAREN;
            5: return CH_SLASH;
            6: return CH_QUOTE;
            default: return CH_NEWLINE;
        endcase
    endfunction

    function automatic logic [7:0] rand_byte();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 65) return 8'($urandom_range(126, 32));
        else if (r < 85) return special_char();
        else return 8'($urandom_range(255));
    endfunction

    function automatic logic [7:0] body_byte(input logic [7:0] avoid);
        logic [7:0] b;
        b = rand_byte();
        while (b == avoid) b = rand_byte();
        return b;
    endfunction

    // a text ends now and then, often in the middle of a comment or string
    function automatic logic end_here();
        return $urandom_range(99) < 2;
    endfunction

    // mostly well-formed pascal pieces with random content, some noise
    task automatic send_fragment();
        int unsigned kind;
        int unsigned len;
        kind = $urandom_range(99);
        len = $urandom_range(5);
        if (kind < 30) begin
            repeat (len + 1) send(8'($urandom_range(126, 32)), end_here());
        end else if (kind < 42) begin
            send(CH_LBRACE, end_here());
            repeat (len) send(body_byte(CH_RBRACE), end_here());
            send(CH_RBRACE, end_here());
        end else if (kind < 54) begin
            send(CH_LPAREN, end_here());
            send(CH_STAR, end_here());
            repeat (len) send(rand_byte(), end_here());
            send(CH_STAR, end_here());
            send(CH_RPAREN, end_here());
        end else if (kind < 64) begin
            send(CH_SLASH, end_here());
            send(CH_SLASH, end_here());
            repeat (len) send(body_byte(CH_NEWLINE), end_here());
            send(CH_NEWLINE, end_here());
        end else if (kind < 78) begin
            send(CH_QUOTE, end_here());
            repeat (len) begin
                if ($urandom_range(4) == 0) begin
                    send(CH_QUOTE, end_here());
                    send(CH_QUOTE, end_here());
                end else begin
                    send(body_byte(CH_QUOTE), end_here());
                end
            end
            send(CH_QUOTE, end_here());
        end else if (kind < 86) begin
            send($urandom_range(1) ? CH_LPAREN : CH_SLASH, end_here());
            send(rand_byte(), end_here());
        end else begin
            repeat (len + 1) send(8'($urandom_range(255)), end_here());
        end
    endtask

    always @(negedge i_clk) begin
        pop <= i_rst_n && ($urandom_range(99) >= recv_idle);
    end

    always @(posedge i_clk) begin : result_check
        t_strip_word want;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("status: fail");
            $finish;
        end else if (i_rst_n && pop && !empty) begin
            if (pending_words.size() == 0) begin
                report_mismatch("word with nothing pending", o_out_char, 8'h00);
            end else begin
                want = pending_words.pop_front();
                if (o_out_char !== want.ch)
                    report_mismatch("out_char", o_out_char, want.ch);
                if (o_out_valid !== want.valid)
                    report_mismatch("out_valid", 8'(o_out_valid), 8'(want.valid));
                if (o_run_last !== want.run_last)
                    report_mismatch("run_last", 8'(o_run_last), 8'(want.run_last));
                if (o_stream_end !== want.stream_end)
                    report_mismatch("stream_end", 8'(o_stream_end), 8'(want.stream_end));
            end
        end
    end

    initial begin
        int unsigned goal;
        add_row(typed_row(8'h41, 1'b0, 2'd1, mk_word(8'h41, 1'b1, 1'b1, 1'b0), '0));
        add_row(typed_row(8'h00, 1'b0, 2'd1, mk_word(8'h00, 1'b1, 1'b1, 1'b0), '0));
        add_row(typed_row(8'hFF, 1'b0, 2'd1, mk_word(8'hFF, 1'b1, 1'b1, 1'b0), '0));
        add_row(plain_row(CH_LBRACE, 1'b0));
        add_row(plain_row(CH_RBRACE, 1'b0));
        // "(*)" must not close the paren comment
        add_row(plain_row(CH_LPAREN, 1'b0));
        add_row(plain_row(CH_STAR, 1'b0));
        add_row(plain_row(CH_RPAREN, 1'b0));
        add_row(plain_row(CH_STAR, 1'b0));
        add_row(plain_row(CH_RPAREN, 1'b0));
        // held paren released by an ordinary byte
        add_row(plain_row(CH_LPAREN, 1'b0));
        add_row(plain_row(8'h62, 1'b0));
        add_row(plain_row(CH_SLASH, 1'b0));
        add_row(plain_row(CH_SLASH, 1'b0));
        add_row(plain_row(CH_NEWLINE, 1'b0));
        // held slash released by a paren, then a held paren flushed on the final byte
        add_row(plain_row(CH_SLASH, 1'b0));
        add_row(plain_row(CH_LPAREN, 1'b0));
        add_row(typed_row(CH_LPAREN, 1'b1, 2'd2, mk_word(CH_LPAREN, 1'b1, 1'b0, 1'b0),
                          mk_word(CH_LPAREN, 1'b1, 1'b1, 1'b1)));
        // string with a doubled quote, ended by an ordinary byte
        add_row(plain_row(CH_QUOTE, 1'b0));
        add_row(plain_row(8'h61, 1'b0));
        add_row(plain_row(CH_QUOTE, 1'b0));
        add_row(plain_row(CH_QUOTE, 1'b0));
        add_row(plain_row(CH_QUOTE, 1'b0));
        add_row(plain_row(8'h3B, 1'b0));
        // final byte opens a comment: only the empty end marker
        add_row(typed_row(CH_LBRACE, 1'b1, 2'd1, mk_word(8'h00, 1'b0, 1'b1, 1'b1), '0));

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_idle = 32;
        recv_idle = 74;
        foreach (dir_rows[i]) begin
            push_byte(dir_rows[i].c, dir_rows[i].last);
            strip_step(dir_rows[i].c, dir_rows[i].last);
            if (dir_rows[i].typed) begin
                owe_word(dir_rows[i].w0);
                if (dir_rows[i].n == 2'd2) owe_word(dir_rows[i].w1);
            end else begin
                foreach (step_words[k]) owe_word(step_words[k]);
            end
        end

        for (int ph = 0; ph < 3; ph++) begin
            if (ph == 1) begin
                send_idle = 74;
                recv_idle = 32;
            end else if (ph == 2) begin
                send_idle = 0;
                recv_idle = 0;
            end
            goal = sent_items + PHASE_GOAL;
            while (sent_items < goal) send_fragment();
            // sender holds off until every owed word is out
            drain();
        end

        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && pending_words.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
